// ===== hw/rtl/lagged_autocovariance_macros.svh =====
// Assertion helpers for the lagged autocovariance block.
// Both macros sample on clk_i and are gated by rst_ni.
`ifndef LAGGED_AUTOCOVARIANCE_MACROS_SVH
`define LAGGED_AUTOCOVARIANCE_MACROS_SVH

`define LAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define LAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  `LAC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/lac_pkg.sv =====
// ----------------------------------------------------------------------------
// lac_pkg
// Shared types and constants of the lagged autocovariance block.
// ----------------------------------------------------------------------------
package lac_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int MAX_SAMPLES = 4096;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int MAX_LAGS    = 64;
  localparam int LAG_W       = 6;
  localparam int LAGN_W      = 7;
  localparam int SKIP_W      = 12;
  localparam int FIRST_W     = SKIP_W + 1;
  localparam int SX_W        = SAMPLE_W + ADDR_W + 1;
  localparam int SXY_W       = 2 * SAMPLE_W + ADDR_W;
  localparam int SXY_LO_W    = SXY_W / 2;
  localparam int SXY_HI_W    = SXY_W - SXY_LO_W;
  localparam int D_W         = SXY_W + CNT_W + 1;
  localparam int FRAC_W      = 8;
  localparam int MAG_W       = D_W + FRAC_W;
  localparam int COV_W       = 39;
  localparam int NSQ_W       = 2 * CNT_W;
  localparam int REM_W       = NSQ_W + 1;
  localparam int DIVC_W      = $clog2(MAG_W + 1);
  localparam int PADDR_W     = 3;

  // register index, taken from paddr[2]
  localparam logic REG_SKIP = 1'b0;
  localparam logic REG_LAGS = 1'b1;

  localparam logic [SKIP_W-1:0] SKIP_RST = '0;
  localparam logic [LAGN_W-1:0] LAGS_RST = LAGN_W'(32);

  typedef struct packed {
    logic [CNT_W-1:0]  total;
    logic [SKIP_W-1:0] skip;
    logic [LAGN_W-1:0] lags;
  } job_t;

  typedef struct packed {
    logic [LAG_W-1:0]         lag;
    logic signed [COV_W-1:0]  cov;
    logic [LAGN_W-1:0]        run;
    logic                     few;
    logic                     fin;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_MUL,
    ST_DIFF,
    ST_DIV,
    ST_EMIT
  } back_state_e;

endpackage

// ===== hw/rtl/lac_ram.sv =====
// ----------------------------------------------------------------------------
// lac_ram
// Sample store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module lac_ram #(
  parameter int Depth = 4096,
  parameter int Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== hw/rtl/lac_front.sv =====
// ----------------------------------------------------------------------------
// lac_front
// Loads samples into the store and queues one job per finished series.
// ----------------------------------------------------------------------------
module lac_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic signed [lac_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                last_i,
  input  logic [lac_pkg::SKIP_W-1:0]          skip_i,
  input  logic [lac_pkg::LAGN_W-1:0]          lags_i,
  input  logic                                back_busy_i,
  input  logic                                job_pop_i,
  output logic                                job_valid_o,
  output lac_pkg::job_t                       job_o,
  output logic                                we_o,
  output logic [lac_pkg::ADDR_W-1:0]          waddr_o,
  output logic [lac_pkg::SAMPLE_W-1:0]        wdata_o
);

  logic [lac_pkg::CNT_W-1:0]  total_q, total_d, total_inc;
  logic                       accept;
  logic [lac_pkg::LAGN_W-1:0] lags_clamp;
  lac_pkg::job_t              jq_q [2];
  logic                       wp_q, rp_q;
  logic [1:0]                 cnt_q;
  logic                       enq;

  // store is shared with the back end, so hold off while a job is in flight
  assign full   = (cnt_q != 2'd0) || back_busy_i;
  assign accept = push && !full;
  assign we_o   = accept && (total_q < lac_pkg::CNT_W'(lac_pkg::MAX_SAMPLES));
  assign waddr_o   = total_q[lac_pkg::ADDR_W-1:0];
  assign wdata_o   = sample_i;
  assign total_inc = total_q + lac_pkg::CNT_W'(we_o);
  assign enq       = accept && last_i;

  always_comb begin
    if (lags_i == '0) begin
      lags_clamp = lac_pkg::LAGN_W'(1);
    end else if (lags_i > lac_pkg::LAGN_W'(lac_pkg::MAX_LAGS)) begin
      lags_clamp = lac_pkg::LAGN_W'(lac_pkg::MAX_LAGS);
    end else begin
      lags_clamp = lags_i;
    end
    total_d = enq ? '0 : total_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      wp_q    <= 1'b0;
      rp_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      total_q <= total_d;
      if (enq) begin
        wp_q <= !wp_q;
      end
      if (job_pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(enq) - 2'(job_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      jq_q[wp_q] <= '{total: total_inc, skip: skip_i, lags: lags_clamp};
    end
  end

  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = jq_q[rp_q];

endmodule

// ===== hw/rtl/lac_back.sv =====
// ----------------------------------------------------------------------------
// lac_back
// Walks the stored series lag by lag and emits one covariance per lag.
// ----------------------------------------------------------------------------
`include "lagged_autocovariance_macros.svh"

module lac_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  lac_pkg::job_t                 job_i,
  output logic                          job_pop_o,
  output logic                          busy_o,
  output logic [lac_pkg::ADDR_W-1:0]    raddr_a_o,
  output logic [lac_pkg::ADDR_W-1:0]    raddr_b_o,
  input  logic [lac_pkg::SAMPLE_W-1:0]  rdata_a_i,
  input  logic [lac_pkg::SAMPLE_W-1:0]  rdata_b_i,
  output logic                          empty,
  input  logic                          pop,
  output lac_pkg::res_t                 res_o
);

  lac_pkg::back_state_e state_q, state_d;
  lac_pkg::job_t        job_q;

  logic [lac_pkg::LAG_W-1:0]     k_q;
  logic [lac_pkg::LAGN_W-1:0]    run_q;
  logic [lac_pkg::FIRST_W-1:0]   first;
  logic [lac_pkg::CNT_W-1:0]     n_q, j_q;
  logic                          rd_vld_q;
  logic                          issue;
  logic signed [lac_pkg::SX_W-1:0]  sx_q, sy_q;
  logic signed [lac_pkg::SXY_W-1:0] sxy_q;
  logic signed [lac_pkg::D_W-1:0]   phi_q, sxsy_q, plo, d_val;
  logic [lac_pkg::NSQ_W-1:0]        nsq_q;
  logic                             neg_q, few_q;
  logic [lac_pkg::MAG_W-1:0]        quo_q;
  logic [lac_pkg::REM_W-1:0]        rem_q, rem_sh;
  logic [lac_pkg::DIVC_W-1:0]       dcnt_q;
  logic signed [lac_pkg::MAG_W-1:0] cov_full;
  logic                             positive;
  logic [lac_pkg::LAGN_W-1:0]       run_next;
  logic                             last_lag;

  lac_pkg::res_t ofq_q [2];
  logic          owp_q, orp_q;
  logic [1:0]    ocnt_q;
  logic          opush;

  assign first    = lac_pkg::FIRST_W'(job_q.skip) + lac_pkg::FIRST_W'(k_q);
  assign issue    = (state_q == lac_pkg::ST_WALK) && (j_q < n_q);
  assign raddr_a_o = lac_pkg::ADDR_W'(lac_pkg::CNT_W'(job_q.skip) + j_q);
  assign raddr_b_o = lac_pkg::ADDR_W'(lac_pkg::CNT_W'(first) + j_q);
  assign busy_o    = (state_q != lac_pkg::ST_IDLE);
  assign job_pop_o = (state_q == lac_pkg::ST_IDLE) && job_valid_i;
  assign last_lag  = (lac_pkg::LAGN_W'(k_q) + 1'b1 == job_q.lags);

  // n*Sxy in two halves: high half is registered in ST_MUL
  assign plo   = lac_pkg::D_W'($signed({1'b0, sxy_q[lac_pkg::SXY_LO_W-1:0]})
                 * $signed({1'b0, n_q}));
  assign d_val = (phi_q <<< lac_pkg::SXY_LO_W) + plo - sxsy_q;

  assign rem_sh = {rem_q[lac_pkg::REM_W-2:0], quo_q[lac_pkg::MAG_W-1]};

  always_comb begin
    if (few_q) begin
      cov_full = '0;
    end else if (neg_q) begin
      cov_full = -$signed(quo_q + lac_pkg::MAG_W'(rem_q != '0));
    end else begin
      cov_full = $signed(quo_q);
    end
    positive = !few_q && (cov_full > 0);
    run_next = (positive && run_q == lac_pkg::LAGN_W'(k_q)) ? run_q + 1'b1 : run_q;
    opush    = (state_q == lac_pkg::ST_EMIT) && (ocnt_q != 2'd2);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lac_pkg::ST_IDLE:  if (job_valid_i) state_d = lac_pkg::ST_SETUP;
      lac_pkg::ST_SETUP: begin
        if (lac_pkg::CNT_W'(first) < job_q.total) begin
          state_d = lac_pkg::ST_WALK;
        end else begin
          state_d = lac_pkg::ST_EMIT;
        end
      end
      lac_pkg::ST_WALK:  if (!issue && !rd_vld_q) state_d = lac_pkg::ST_MUL;
      lac_pkg::ST_MUL:   state_d = lac_pkg::ST_DIFF;
      lac_pkg::ST_DIFF:  state_d = lac_pkg::ST_DIV;
      lac_pkg::ST_DIV:   if (dcnt_q == '0) state_d = lac_pkg::ST_EMIT;
      lac_pkg::ST_EMIT: begin
        if (opush) begin
          state_d = last_lag ? lac_pkg::ST_IDLE : lac_pkg::ST_SETUP;
        end
      end
      default: state_d = lac_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lac_pkg::ST_IDLE;
      rd_vld_q <= 1'b0;
      k_q      <= '0;
      run_q    <= '0;
      owp_q    <= 1'b0;
      orp_q    <= 1'b0;
      ocnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (job_pop_o) begin
        k_q   <= '0;
        run_q <= '0;
      end else if (opush) begin
        k_q   <= k_q + 1'b1;
        run_q <= run_next;
      end
      if (opush) begin
        owp_q <= !owp_q;
      end
      if (pop && !empty) begin
        orp_q <= !orp_q;
      end
      ocnt_q <= ocnt_q + 2'(opush) - 2'(pop && !empty);
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    case (state_q)
      lac_pkg::ST_SETUP: begin
        n_q   <= job_q.total - lac_pkg::CNT_W'(first);
        few_q <= !(lac_pkg::CNT_W'(first) < job_q.total);
        j_q   <= '0;
        sx_q  <= '0;
        sy_q  <= '0;
        sxy_q <= '0;
      end
      lac_pkg::ST_WALK: begin
        if (issue) begin
          j_q <= j_q + 1'b1;
        end
        if (rd_vld_q) begin
          sx_q  <= sx_q + lac_pkg::SX_W'($signed(rdata_a_i));
          sy_q  <= sy_q + lac_pkg::SX_W'($signed(rdata_b_i));
          sxy_q <= sxy_q + lac_pkg::SXY_W'($signed(rdata_a_i) * $signed(rdata_b_i));
        end
      end
      lac_pkg::ST_MUL: begin
        phi_q  <= lac_pkg::D_W'($signed(sxy_q[lac_pkg::SXY_W-1:lac_pkg::SXY_LO_W])
                  * $signed({1'b0, n_q}));
        sxsy_q <= lac_pkg::D_W'(sx_q * sy_q);
        nsq_q  <= n_q * n_q;
      end
      lac_pkg::ST_DIFF: begin
        neg_q  <= d_val[lac_pkg::D_W-1];
        quo_q  <= {(d_val[lac_pkg::D_W-1] ? -d_val : d_val), lac_pkg::FRAC_W'(0)};
        rem_q  <= '0;
        dcnt_q <= lac_pkg::DIVC_W'(lac_pkg::MAG_W - 1);
      end
      lac_pkg::ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (rem_sh >= lac_pkg::REM_W'(nsq_q)) begin
          rem_q <= rem_sh - lac_pkg::REM_W'(nsq_q);
          quo_q <= {quo_q[lac_pkg::MAG_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[lac_pkg::MAG_W-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 1'b1;
      end
      default: ;
    endcase
    if (opush) begin
      ofq_q[owp_q] <= '{lag: k_q, cov: lac_pkg::COV_W'(cov_full), run: run_next,
                        few: few_q, fin: last_lag};
    end
  end

  assign empty = (ocnt_q == 2'd0);
  assign res_o = ofq_q[orp_q];

  `LAC_ASSERT(a_ofq_bound, ocnt_q != 2'd3, "result queue overflow")
  `LAC_ASSERT(a_rd_in_series, issue |-> (lac_pkg::CNT_W'(first) + j_q < job_q.total),
    "pair read beyond stored series")
  `LAC_ASSERT_NEXT(a_rd_follows_walk, issue, rd_vld_q, "read data not tracked")
  `LAC_ASSERT(a_no_pop_busy, job_pop_o |-> !busy_o, "job taken while busy")

endmodule

// ===== hw/rtl/lagged_autocovariance.sv =====
// ----------------------------------------------------------------------------
// lagged_autocovariance
// Sample autocovariance by lag of one stored integer series.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+-----------------------------------------
//  sample   | push / full      | sample_i, last_i
//  result   | pop / empty      | lag_o, covariance_o, positive_run_o,
//           |                  | too_few_o, final_res_o
//  config   | APB psel/penable | skip_count @0x0, lag_count @0x4
//
// Samples load at one per cycle while full is low. A last request starts
// evaluation; full stays high until every lag is done. Each lag runs setup,
// the pair walk (two store read ports), multiply, difference, a restoring
// divider and emit; with too few pairs it goes from setup to emit. Results
// stall the back end when the 2-entry output queue is full. Reset clears the
// sample count and configuration; the store itself is not cleared.
module lagged_autocovariance (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic signed [lac_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                last_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [lac_pkg::LAG_W-1:0]           lag_o,
  output logic signed [lac_pkg::COV_W-1:0]    covariance_o,
  output logic [lac_pkg::LAGN_W-1:0]          positive_run_o,
  output logic                                too_few_o,
  output logic                                final_res_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lac_pkg::PADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [lac_pkg::SKIP_W-1:0] skip_q;
  logic [lac_pkg::LAGN_W-1:0] lags_q;
  logic                       cfg_wr;

  logic                         job_valid, job_pop, back_busy, we;
  lac_pkg::job_t                job;
  logic [lac_pkg::ADDR_W-1:0]   waddr, raddr_a, raddr_b;
  logic [lac_pkg::SAMPLE_W-1:0] wdata, rdata_a, rdata_b;
  lac_pkg::res_t                res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= lac_pkg::SKIP_RST;
      lags_q <= lac_pkg::LAGS_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        lac_pkg::REG_SKIP: skip_q <= pwdata[lac_pkg::SKIP_W-1:0];
        lac_pkg::REG_LAGS: lags_q <= pwdata[lac_pkg::LAGN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      lac_pkg::REG_SKIP: prdata = 32'(skip_q);
      lac_pkg::REG_LAGS: prdata = 32'(lags_q);
      default:           prdata = '0;
    endcase
  end

  lac_front u_front (
    .clk_i, .rst_ni, .push, .full, .sample_i, .last_i,
    .skip_i(skip_q), .lags_i(lags_q), .back_busy_i(back_busy),
    .job_pop_i(job_pop), .job_valid_o(job_valid), .job_o(job),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata)
  );

  lac_ram #(.Depth(lac_pkg::MAX_SAMPLES), .Width(lac_pkg::SAMPLE_W)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_a_i(raddr_a), .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a), .rdata_b_o(rdata_b)
  );

  lac_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_i(job), .job_pop_o(job_pop),
    .busy_o(back_busy), .raddr_a_o(raddr_a), .raddr_b_o(raddr_b),
    .rdata_a_i(rdata_a), .rdata_b_i(rdata_b), .empty, .pop, .res_o(res)
  );

  assign lag_o          = res.lag;
  assign covariance_o   = res.cov;
  assign positive_run_o = res.run;
  assign too_few_o      = res.few;
  assign final_res_o    = res.fin;

endmodule
